>>> rtl/dtc_pkg.sv
// Shared constants, action codes and tap selection for the divider/timer unit.
// No dependencies; used by divider_timer_counter_unit and dtc_checker.
`timescale 1ns / 1ps
`default_nettype none

package dtc_pkg;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    localparam logic [15:0] ADDR_DIVIDER  = 16'hFF04;
    localparam logic [15:0] ADDR_COUNTER  = 16'hFF05;
    localparam logic [15:0] ADDR_RELOAD   = 16'hFF06;
    localparam logic [15:0] ADDR_CONTROL  = 16'hFF07;
    localparam logic [15:0] DIVIDER_RESET = 16'hAC00;
    localparam int unsigned ENABLE_BIT    = 2;

    // divider bit watched for a falling edge, per control_byte[1:0]
    function automatic logic [3:0] tap_index(input logic [1:0] sel);
        logic [3:0] idx;
        unique case (sel)
            2'd0: idx = 4'd9;
            2'd1: idx = 4'd3;
            2'd2: idx = 4'd5;
            2'd3: idx = 4'd7;
            default: idx = 4'd9;
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> rtl/divider_timer_counter_unit.sv
// Divider / timer-counter unit: top level, all state and the result register.
// Depends on dtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One request is a tick, a bus read or a bus write; every request gives
// exactly one result (read_data, interrupt_request). A request is taken in
// every cycle with in_stall low: its effect on the divider, counter, reload
// and control registers is applied at the edge that accepts it, and its
// result lands in a one-entry output register the same edge, so throughput
// is one request per cycle unless stalled. The input only stalls while the
// output register holds a result the consumer is stalling. A tick advances the
// 16-bit divider; a falling edge on divider bit 9, 3, 5 or 7 (control[1:0])
// with control[2] set bumps the counter, and a wrap from 255 reloads it and
// raises interrupt_request for that tick. Bus map: FF04 divider (read upper
// byte, any write clears it), FF05 counter, FF06 reload, FF07 control; other
// addresses read 0 and ignore writes. Action code 3 is a no-op with a zero
// result.
module divider_timer_counter_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  write_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       read_data,
    output logic             interrupt_request
);

    logic [15:0] divider_reg, divider_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  reload_reg, reload_next;
    logic [7:0]  control_reg, control_next;
    logic        out_valid_reg;
    logic [7:0]  rdata_reg, rdata_next;
    logic        irq_reg, irq_next;

    logic        accept;
    logic [15:0] div_inc;
    logic [3:0]  tap;
    logic        fell;
    dtc_pkg::action_t act;

    // output register frees up when it is empty or being drained
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;
    assign act      = dtc_pkg::action_t'(action);

    assign div_inc = divider_reg + 16'd1;
    assign tap     = dtc_pkg::tap_index(control_reg[1:0]);
    assign fell    = divider_reg[tap] & ~div_inc[tap];

    always_comb
    begin
        divider_next = divider_reg;
        count_next   = count_reg;
        reload_next  = reload_reg;
        control_next = control_reg;
        rdata_next   = 8'd0;
        irq_next     = 1'b0;
        unique case (act)
            dtc_pkg::ACT_TICK:
            begin
                divider_next = div_inc;
                if (fell && control_reg[dtc_pkg::ENABLE_BIT])
                begin
                    if (count_reg == 8'hFF)
                    begin
                        count_next = reload_reg;
                        irq_next   = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 8'd1;
                    end
                end
            end
            dtc_pkg::ACT_READ:
            begin
                unique case (address)
                    dtc_pkg::ADDR_DIVIDER: rdata_next = divider_reg[15:8];
                    dtc_pkg::ADDR_COUNTER: rdata_next = count_reg;
                    dtc_pkg::ADDR_RELOAD:  rdata_next = reload_reg;
                    dtc_pkg::ADDR_CONTROL: rdata_next = control_reg;
                    default:               rdata_next = 8'd0;
                endcase
            end
            dtc_pkg::ACT_WRITE:
            begin
                unique case (address)
                    dtc_pkg::ADDR_DIVIDER: divider_next = 16'd0;
                    dtc_pkg::ADDR_COUNTER: count_next   = write_data;
                    dtc_pkg::ADDR_RELOAD:  reload_next  = write_data;
                    dtc_pkg::ADDR_CONTROL: control_next = write_data;
                    default: ;
                endcase
            end
            dtc_pkg::ACT_NOP: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg   <= dtc_pkg::DIVIDER_RESET;
            count_reg     <= 8'd0;
            reload_reg    <= 8'd0;
            control_reg   <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                divider_reg <= divider_next;
                count_reg   <= count_next;
                reload_reg  <= reload_next;
                control_reg <= control_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= rdata_next;
            irq_reg   <= irq_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign read_data         = rdata_reg;
    assign interrupt_request = irq_reg;

endmodule

`default_nettype wire

>>> rtl/dtc_checker.sv
// Port-level checker for divider_timer_counter_unit, plus its bind.
// Depends on dtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [1:0]  action,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  read_data,
    input wire logic        interrupt_request
);

    logic in_acc;
    assign in_acc = in_valid & ~in_stall;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data)
            && $stable(interrupt_request))
        else $error("stalled result changed");

    // input only stalls behind a waiting result
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && action == dtc_pkg::ACT_TICK |=> out_valid && read_data == 8'd0)
        else $error("tick result wrong");

    a_read_no_irq: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && action == dtc_pkg::ACT_READ |=> out_valid && !interrupt_request)
        else $error("read raised interrupt");

    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (action == dtc_pkg::ACT_WRITE || action == dtc_pkg::ACT_NOP)
            |=> out_valid && read_data == 8'd0 && !interrupt_request)
        else $error("write result not zero");

endmodule

bind divider_timer_counter_unit dtc_checker u_dtc_checker (.*);

`default_nettype wire
